/* hdl/twsm_pkg.sv */
// ---------------------------------------------------------------------------
// twsm_pkg
// Shared types, codes and tables for the two-wire sensor measurement master.
// ---------------------------------------------------------------------------
`default_nettype none

package twsm_pkg;

  // Protocol phases of one measurement transaction
  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_START = 5'd1,
    PH_CSET  = 5'd2,
    PH_CHI   = 5'd3,
    PH_CLO   = 5'd4,
    PH_ACK0  = 5'd5,
    PH_ACK1  = 5'd6,
    PH_ACK2  = 5'd7,
    PH_POLL  = 5'd8,
    PH_RREL  = 5'd9,
    PH_RHI   = 5'd10,
    PH_RLO   = 5'd11,
    PH_MACK0 = 5'd12,
    PH_MACK1 = 5'd13,
    PH_MACK2 = 5'd14,
    PH_MACK3 = 5'd15,
    PH_MACK4 = 5'd16,
    PH_CRC0  = 5'd17,
    PH_CRC1  = 5'd18,
    PH_CRC2  = 5'd19
  } phase_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_STEP_TICKS    = 2'd0;
  localparam logic [1:0] CFG_POLL_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_POLL_LIMIT    = 2'd2;

  localparam logic [15:0] STEP_TICKS_RST    = 16'd1;
  localparam logic [7:0]  POLL_INTERVAL_RST = 8'd2;
  localparam logic [7:0]  POLL_LIMIT_RST    = 8'd200;

  // Sensor commands
  localparam logic [7:0] CMD_TEMP  = 8'h03;
  localparam logic [7:0] CMD_HUMID = 8'h05;

  localparam logic [3:0] START_STEPS = 4'd10;
  localparam logic [3:0] BYTE_BITS   = 4'd8;

  // Request kinds (s_tuser)
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Result tdata layout, low bit up
  localparam int OB_CLK     = 0;
  localparam int OB_DRIVE   = 1;
  localparam int OB_LEVEL   = 2;
  localparam int OB_BUSY    = 3;
  localparam int OB_DONE    = 4;
  localparam int OB_RAW_LO  = 5;
  localparam int OB_RAW_HI  = 20;
  localparam int OB_TIMEOUT = 21;

  typedef struct packed {
    logic [15:0] step_ticks;
    logic [7:0]  poll_interval_steps;
    logic [7:0]  poll_limit;
  } cfg_t;

  typedef struct packed {
    logic clk;
    logic drive;
    logic level;
  } lines_t;

  typedef struct packed {
    logic        clock_level;
    logic        data_drive;
    logic        data_level;
    logic        busy_res;
    logic        done_res;
    logic [15:0] raw_value;
    logic        timed_out;
  } res_t;

  // Bus levels for each step of the transmission-start pattern
  function automatic lines_t start_lines(input logic [3:0] sub);
    lines_t l;
    l = '{clk: 1'b0, drive: 1'b0, level: 1'b0};
    case (sub)
      4'd0, 4'd1: l = '{clk: 1'b0, drive: 1'b0, level: 1'b0};
      4'd2:       l = '{clk: 1'b0, drive: 1'b1, level: 1'b1};
      4'd3:       l = '{clk: 1'b1, drive: 1'b1, level: 1'b1};
      4'd4:       l = '{clk: 1'b1, drive: 1'b1, level: 1'b0};
      4'd5:       l = '{clk: 1'b0, drive: 1'b1, level: 1'b0};
      4'd6:       l = '{clk: 1'b1, drive: 1'b1, level: 1'b0};
      4'd7:       l = '{clk: 1'b1, drive: 1'b1, level: 1'b1};
      4'd8:       l = '{clk: 1'b0, drive: 1'b1, level: 1'b1};
      default:    l = '{clk: 1'b0, drive: 1'b1, level: 1'b0};
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

/* hdl/twsm_core.sv */
// ---------------------------------------------------------------------------
// twsm_core
// Protocol sequencer: advances one request per enable, gives its result.
// ---------------------------------------------------------------------------
`default_nettype none

module twsm_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_en,
  input  wire logic           req,
  input  wire logic           kind,
  input  wire logic           din,
  input  wire twsm_pkg::cfg_t cfg,
  output twsm_pkg::res_t      res
);
  import twsm_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  poll_count, poll_count_next;
  logic [7:0]  command_shift, command_shift_next;
  logic [15:0] read_shift, read_shift_next;
  logic        timeout_flag, timeout_flag_next;
  logic [7:0]  interval_steps, interval_steps_next;
  logic [3:0]  start_sub, start_sub_next;
  logic        step_done;

  logic [15:0] tick_inc;
  logic [8:0]  interval_inc;
  logic [7:0]  poll_inc;
  logic [3:0]  sub_inc;
  logic [3:0]  bit_inc;

  assign tick_inc     = tick_count + 16'd1;
  assign interval_inc = {1'b0, interval_steps} + 9'd1;
  assign poll_inc     = poll_count + 8'd1;
  assign sub_inc      = start_sub + 4'd1;
  assign bit_inc      = bit_index + 4'd1;

  always_comb begin : next_state
    phase_next          = phase;
    bit_index_next      = bit_index;
    tick_count_next     = tick_count;
    poll_count_next     = poll_count;
    command_shift_next  = command_shift;
    read_shift_next     = read_shift;
    timeout_flag_next   = timeout_flag;
    interval_steps_next = interval_steps;
    start_sub_next      = start_sub;
    step_done           = 1'b0;
    if (req == REQ_START) begin
      // a start while busy is dropped
      if (phase == PH_IDLE) begin
        phase_next          = PH_START;
        start_sub_next      = '0;
        tick_count_next     = '0;
        bit_index_next      = '0;
        poll_count_next     = '0;
        interval_steps_next = '0;
        read_shift_next     = '0;
        timeout_flag_next   = 1'b0;
        command_shift_next  = kind ? CMD_HUMID : CMD_TEMP;
      end
    end else if (phase != PH_IDLE) begin
      tick_count_next = tick_inc;
      if (tick_inc >= cfg.step_ticks) begin
        tick_count_next = '0;
        case (phase)
          PH_START: begin
            start_sub_next = sub_inc;
            if (sub_inc >= START_STEPS) begin
              phase_next     = PH_CSET;
              bit_index_next = '0;
            end
          end
          PH_CSET: phase_next = PH_CHI;
          PH_CHI:  phase_next = PH_CLO;
          PH_CLO: begin
            command_shift_next = {command_shift[6:0], 1'b0};
            bit_index_next     = bit_inc;
            phase_next         = (bit_inc >= BYTE_BITS) ? PH_ACK0 : PH_CSET;
          end
          PH_ACK0: phase_next = PH_ACK1;
          PH_ACK1: phase_next = PH_ACK2;
          PH_ACK2: begin
            phase_next          = PH_POLL;
            poll_count_next     = '0;
            interval_steps_next = '0;
          end
          PH_POLL: begin
            if (interval_inc >= {1'b0, cfg.poll_interval_steps}) begin
              interval_steps_next = '0;
              poll_count_next     = poll_inc;
              if (!din) begin
                phase_next      = PH_RREL;
                bit_index_next  = '0;
                read_shift_next = '0;
              end else if (poll_inc >= cfg.poll_limit) begin
                // timeout is flagged only, the read goes on
                timeout_flag_next = 1'b1;
                phase_next        = PH_RREL;
                bit_index_next    = '0;
                read_shift_next   = '0;
              end
            end else begin
              interval_steps_next = interval_inc[7:0];
            end
          end
          PH_RREL: phase_next = PH_RHI;
          PH_RHI: begin
            read_shift_next = {read_shift[14:0], din};
            bit_index_next  = bit_inc;
            phase_next      = PH_RLO;
          end
          PH_RLO: begin
            // index wraps to zero after the second byte
            if (bit_index == BYTE_BITS) begin
              phase_next = PH_MACK0;
            end else if (bit_index == 4'd0) begin
              phase_next = PH_CRC0;
            end else begin
              phase_next = PH_RHI;
            end
          end
          PH_MACK0: phase_next = PH_MACK1;
          PH_MACK1: phase_next = PH_MACK2;
          PH_MACK2: phase_next = PH_MACK3;
          PH_MACK3: phase_next = PH_MACK4;
          PH_MACK4: phase_next = PH_RREL;
          PH_CRC0:  phase_next = PH_CRC1;
          PH_CRC1:  phase_next = PH_CRC2;
          PH_CRC2: begin
            phase_next = PH_IDLE;
            step_done  = 1'b1;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // Bus levels after this request is applied
  always_comb begin : outputs
    lines_t l;
    l = '{clk: 1'b0, drive: 1'b0, level: 1'b0};
    case (phase_next)
      PH_START: l = start_lines(start_sub_next);
      PH_CSET, PH_CLO:
        l = '{clk: 1'b0, drive: 1'b1, level: command_shift_next[7]};
      PH_CHI:
        l = '{clk: 1'b1, drive: 1'b1, level: command_shift_next[7]};
      PH_ACK1, PH_RHI:
        l = '{clk: 1'b1, drive: 1'b0, level: 1'b0};
      PH_MACK0, PH_MACK1, PH_CRC0, PH_CRC2:
        l = '{clk: 1'b0, drive: 1'b1, level: 1'b1};
      PH_MACK2, PH_MACK4:
        l = '{clk: 1'b0, drive: 1'b1, level: 1'b0};
      PH_MACK3:
        l = '{clk: 1'b1, drive: 1'b1, level: 1'b0};
      PH_CRC1:
        l = '{clk: 1'b1, drive: 1'b1, level: 1'b1};
      default: l = '{clk: 1'b0, drive: 1'b0, level: 1'b0};
    endcase
    res.clock_level = l.clk;
    res.data_drive  = l.drive;
    res.data_level  = l.level;
    res.busy_res    = (phase_next != PH_IDLE);
    res.done_res    = step_done;
    res.raw_value   = step_done ? read_shift_next : 16'd0;
    res.timed_out   = timeout_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_index      <= '0;
      tick_count     <= '0;
      poll_count     <= '0;
      command_shift  <= '0;
      read_shift     <= '0;
      timeout_flag   <= 1'b0;
      interval_steps <= '0;
      start_sub      <= '0;
    end else if (item_en) begin
      phase          <= phase_next;
      bit_index      <= bit_index_next;
      tick_count     <= tick_count_next;
      poll_count     <= poll_count_next;
      command_shift  <= command_shift_next;
      read_shift     <= read_shift_next;
      timeout_flag   <= timeout_flag_next;
      interval_steps <= interval_steps_next;
      start_sub      <= start_sub_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/two_wire_sensor_measurement_master.sv */
// ---------------------------------------------------------------------------
// two_wire_sensor_measurement_master
// Bit-level master for a two-wire sensor temperature/humidity measurement.
// ---------------------------------------------------------------------------
// Usage:
//  - Input stream (s_*): each request is either a time tick (s_tuser = 0) or
//    a start request (s_tuser = 1). s_tdata[0] picks the measurement
//    (0 temperature, 1 humidity), s_tdata[1] is the sampled data line.
//  - Output stream (m_*): exactly one result per request, in order: clock
//    and data line levels to drive, busy, done, raw value and timeout flag.
//  - Every protocol delay step lasts step_ticks tick requests. A start while
//    a transaction runs is dropped and does not count as a tick.
//  - Result is registered: out in the cycle after the request is taken.
//    Throughput: one request per cycle unless stalled; the sequencer does a
//    constant amount of work per request, bounded by one 16-bit tick compare.
//  - The result register frees on the cycle it is taken, so a new request
//    is accepted while the previous result is handed over. When the
//    receiver stalls, s_tready drops until the waiting result is taken.
//  - Reset (rst, synchronous): sequencer idle, output empty, registers back
//    to step_ticks 1, poll interval 2 steps, poll limit 200.
//  - Configuration: cfg_we writes cfg_wdata to register cfg_addr; write
//    only while no transaction is running.
// ---------------------------------------------------------------------------
`default_nettype none

module two_wire_sensor_measurement_master (
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] measure_kind, [1] data_in, rest 0
  input  wire logic        s_tuser,   // [0] req_type
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [0] clock_level, [1] data_drive,
                                      // [2] data_level, [3] busy_res,
                                      // [4] done_res, [20:5] raw_value,
                                      // [21] timed_out, rest 0
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);
  import twsm_pkg::*;

  cfg_t cfg;
  res_t res;
  logic accept;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_ticks          <= STEP_TICKS_RST;
      cfg.poll_interval_steps <= POLL_INTERVAL_RST;
      cfg.poll_limit          <= POLL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_STEP_TICKS:    cfg.step_ticks          <= cfg_wdata;
        CFG_POLL_INTERVAL: cfg.poll_interval_steps <= cfg_wdata[7:0];
        CFG_POLL_LIMIT:    cfg.poll_limit          <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // take a request whenever the result slot is empty or being emptied
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  twsm_core u_core (
    .clk     (clk),
    .rst     (rst),
    .item_en (accept),
    .req     (s_tuser),
    .kind    (s_tdata[0]),
    .din     (s_tdata[1]),
    .cfg     (cfg),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'b00, res.timed_out, res.raw_value, res.done_res, res.busy_res,
                  res.data_level, res.data_drive, res.clock_level};
    end
  end

endmodule

`default_nettype wire

/* hdl/twsm_checker.sv */
// ---------------------------------------------------------------------------
// twsm_checker
// Port-level assertions for the measurement master, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module twsm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);
  import twsm_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // done means the transaction has ended
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OB_DONE] |-> !m_tdata[OB_BUSY])
    else $error("done reported while busy");

  // raw value only on the done result
  a_raw_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[OB_DONE] |-> m_tdata[OB_RAW_HI:OB_RAW_LO] == 16'd0)
    else $error("raw value outside done");

  // idle bus: clock low, data released
  a_idle_bus: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[OB_BUSY]
      |-> !m_tdata[OB_CLK] && !m_tdata[OB_DRIVE] && !m_tdata[OB_LEVEL])
    else $error("bus not idle while not busy");

  // a result appears after each taken request
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("taken request gave no result");

endmodule

bind two_wire_sensor_measurement_master twsm_checker u_twsm_checker (.*);

`default_nettype wire
